// ----- hw/rtl/olis_pkg.sv -----
// Package for the ordered list block: word types, command and status codes,
// cell control struct and default sizes. No dependencies.
`timescale 1ns / 1ps
package olis_pkg;

  localparam int OLIS_CAPACITY = 16;
  localparam int OLIS_VW       = 32;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } olis_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [4:0] entry_count;
  } olis_rsp_t;

  typedef struct packed {
    logic compare;  // capture per-cell match against incoming key
    logic push;     // shift toward the back, key enters at the front
    logic pull;     // cells at or behind the first match take the next entry
  } olis_cell_ctl_t;

endpackage

// ----- hw/rtl/olis_cell.sv -----
// One list cell: holds an entry and its match flag, passes entries to neighbors.
// Depends on olis_pkg.
`timescale 1ns / 1ps
module olis_cell
  import olis_pkg::*;
#(
  parameter int VW = OLIS_VW
) (
  input  logic           clk,
  input  olis_cell_ctl_t ctl,
  input  logic           occ,
  input  logic [VW-1:0]  key,
  input  logic [VW-1:0]  prev_entry,
  input  logic [VW-1:0]  next_entry,
  input  logic           chain_in,
  output logic           chain_out,
  output logic [VW-1:0]  entry
);

  logic hit;

  assign chain_out = chain_in | hit;

  always_ff @(posedge clk) begin
    if (ctl.compare) begin
      hit <= occ && (entry == key);
    end
    if (ctl.push) begin
      entry <= prev_entry;
    end else if (ctl.pull && chain_out) begin
      entry <= next_entry;
    end
  end

endmodule

// ----- hw/rtl/ordered_list_insert_delete_search.sv -----
// Top level of the ordered list: control FSM, entry count and the cell row.
// Depends on olis_pkg and olis_cell.
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit words, newest at the front.
// A word is taken when start is high and busy is low: the accept edge
// compares the key in all cells at once, the next edge ripples the
// first-match flag along the cell row, shifts the row and registers the
// result. The result is shown with done for one cycle, the cycle in which
// busy drops, and cannot be held off. The first-match ripple along the row
// sets the cycle time of the apply step.
module ordered_list_insert_delete_search
  import olis_pkg::*;
#(
  parameter int CAPACITY = OLIS_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  olis_req_t request,
  output logic      done,
  output olis_rsp_t result
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  count, count_next;
  logic [1:0]     cmd;
  logic [31:0]    key;
  logic           full, any_hit, accept;
  logic [1:0]     status_next;
  logic [CW+4:0]  count_ext;
  olis_cell_ctl_t ctl;

  logic [31:0]     entries [CAPACITY];
  logic [CAPACITY:0] chain;
  logic [CAPACITY-1:0] occ;

  assign accept = start && !busy;
  assign busy   = (state == S_APPLY);
  assign full   = (count == CW'(CAPACITY));
  assign any_hit = chain[CAPACITY];

  assign ctl.compare = accept;
  assign ctl.push    = (state == S_APPLY) && (cmd == CMD_ADD) && !full;
  assign ctl.pull    = (state == S_APPLY) && (cmd == CMD_DELETE);

  assign chain[0] = 1'b0;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [31:0] prev_e, next_e;
      assign occ[i] = (CW'(i) < count);
      if (i == 0) begin : g_front
        assign prev_e = key;
      end else begin : g_mid
        assign prev_e = entries[i-1];
      end
      if (i == CAPACITY - 1) begin : g_back
        assign next_e = entries[i];
      end else begin : g_inner
        assign next_e = entries[i+1];
      end
      olis_cell #(.VW(32)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occ[i]),
        .key       (request.value),
        .prev_entry(prev_e),
        .next_entry(next_e),
        .chain_in  (chain[i]),
        .chain_out (chain[i+1]),
        .entry     (entries[i])
      );
    end
  endgenerate

  always_comb begin
    state_next  = state;
    count_next  = count;
    status_next = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_APPLY;
      end
      S_APPLY: begin
        state_next = S_IDLE;
        priority if (cmd == CMD_ADD) begin
          if (full) status_next = ST_FULL;
          else count_next = count + CW'(1);
        end else if (cmd == CMD_DELETE) begin
          if (any_hit) count_next = count - CW'(1);
          else status_next = ST_MISSING;
        end else begin
          status_next = any_hit ? ST_OK : ST_MISSING;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign count_ext = {5'd0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= (state == S_APPLY);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= request.command;
      key <= request.value;
    end
    if (state == S_APPLY) begin
      result.status      <= status_next;
      result.found       <= any_hit;
      result.entry_count <= count_ext[4:0];
    end
  end

endmodule

// ----- hw/rtl/olis_checker.sv -----
// Port-level checks for the ordered list top level, bound onto it.
// Depends on olis_pkg and ordered_list_insert_delete_search.
`timescale 1ns / 1ps
module olis_checker
  import olis_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input olis_rsp_t result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("apply cycle not followed by a result");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a word in work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_OK || result.status == ST_MISSING ||
              result.status == ST_FULL))
    else $error("bad status code");

  a_found_status: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_MISSING |-> !result.found)
    else $error("missing status with found set");

endmodule

bind ordered_list_insert_delete_search olis_checker u_olis_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ----- tb/ordered_list_insert_delete_search_test.sv -----
// Self-checking testbench for ordered_list_insert_delete_search: directed and random
// add/delete/find words, checked against an in-bench list predictor.
// Depends on olis_pkg and the block's RTL.
`timescale 1ns / 1ps
module ordered_list_insert_delete_search_test;
  import olis_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;  // unused code, behaves as find
  localparam int STALL_LIMIT = 200;
  localparam int RANDOM_WORDS = 1275;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  olis_req_t request = '0;
  logic      done;
  olis_rsp_t result;

  ordered_list_insert_delete_search dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  olis_req_t queued_words[$];
  olis_rsp_t awaited_results[$];

  // list predictor state, front at index 0
  logic signed [31:0] cells[OLIS_CAPACITY];
  int held = 0;

  int errors = 0;
  int result_index = 0;
  int quiet = 0;
  logic took = 1'b0;
  int gap_left = 0;
  int burst_left = 1;

  int n_add = 0, n_refused = 0, n_delete = 0, n_missed = 0, n_find = 0, n_hit = 0;
  int n_spare = 0, deepest = 0;

  function automatic olis_rsp_t apply_to_list(olis_req_t w);
    olis_rsp_t r;
    int pos;
    pos = held;
    for (int i = held - 1; i >= 0; i--)
      if (cells[i] == w.value) pos = i;
    r.found = (pos < held);
    r.status = ST_OK;
    case (w.command)
      CMD_ADD: begin
        n_add++;
        if (held >= OLIS_CAPACITY) begin
          r.status = ST_FULL;
          n_refused++;
        end else begin
          for (int i = held; i > 0; i--) cells[i] = cells[i - 1];
          cells[0] = w.value;
          held++;
        end
      end
      CMD_DELETE: begin
        n_delete++;
        if (!r.found) begin
          r.status = ST_MISSING;
          n_missed++;
        end else begin
          for (int i = pos; i < held - 1; i++) cells[i] = cells[i + 1];
          held--;
        end
      end
      default: begin
        n_find++;
        if (w.command == CMD_SPARE) n_spare++;
        if (r.found) n_hit++;
        r.status = r.found ? ST_OK : ST_MISSING;
      end
    endcase
    if (held > deepest) deepest = held;
    r.entry_count = held[4:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on result %0d: %s got %0d, expected %0d",
             result_index, what, got, want);
    errors++;
  endtask

  task automatic queue_word(input logic [1:0] cmd, input logic signed [31:0] val);
    olis_req_t w;
    w.command = cmd;
    w.value = val;
    queued_words.push_back(w);
  endtask

  // driver: words go out at the falling edge
  always @(negedge clk) begin : drive
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (queued_words.size() > 0) begin
        request <= queued_words.pop_front();
        start <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results, then predict for the word taken at this edge
  always @(posedge clk) begin : monitor
    olis_rsp_t want;
    took <= !rst && start && !busy;
    if (rst) begin
      quiet <= 0;
    end else begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          report("result with nothing pending,", 32'(result), '0);
        end else begin
          want = awaited_results.pop_front();
          if (result.status !== want.status)
            report("status", 32'(result.status), 32'(want.status));
          if (result.found !== want.found)
            report("found", 32'(result.found), 32'(want.found));
          if (result.entry_count !== want.entry_count)
            report("entry_count", 32'(result.entry_count), 32'(want.entry_count));
        end
        result_index++;
      end
      if (start && !busy) awaited_results.push_back(apply_to_list(request));
      quiet <= (done || (start && !busy)) ? 0 : quiet + 1;
    end
  end

  initial begin : watchdog
    wait (quiet >= STALL_LIMIT);
    $display("[ordered_list_insert_delete_search] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic signed [31:0] pool[8];
    int mode, span, r, made;
    logic [1:0] cmd;
    logic signed [31:0] val;

    // empty list, then fill to capacity, then the full and delete corners
    queue_word(CMD_FIND, 32'sd0);
    queue_word(CMD_DELETE, 32'sd5);
    queue_word(CMD_SPARE, 32'sh80000000);
    queue_word(CMD_ADD, 32'sh80000000);
    queue_word(CMD_ADD, 32'sh7fffffff);
    queue_word(CMD_ADD, 32'sd0);
    queue_word(CMD_ADD, -32'sd1);
    queue_word(CMD_ADD, 32'sd1);
    queue_word(CMD_ADD, 32'sh55555555);
    queue_word(CMD_ADD, 32'shaaaaaaaa);
    queue_word(CMD_ADD, 32'sh7fffffff);
    for (int i = 0; i < 8; i++) queue_word(CMD_ADD, $urandom);
    queue_word(CMD_ADD, 32'sh7fffffff);
    queue_word(CMD_ADD, 32'sh12345678);
    queue_word(CMD_DELETE, 32'sh80000000);
    queue_word(CMD_DELETE, 32'sh7fffffff);
    queue_word(CMD_FIND, 32'sh7fffffff);
    queue_word(CMD_SPARE, 32'sd0);

    // random phases: add-heavy, delete-heavy or mixed, values mostly from a
    // slowly changing pool so deletes and finds hit often
    for (int i = 0; i < 8; i++) pool[i] = $urandom;
    made = 0;
    while (made < RANDOM_WORDS) begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 60);
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(0, 5))
          0: pool[$urandom_range(0, 7)] = 32'sh80000000;
          1: pool[$urandom_range(0, 7)] = 32'sh7fffffff;
          2: pool[$urandom_range(0, 7)] = -32'sd1;
          default: pool[$urandom_range(0, 7)] = $urandom;
        endcase
      end
      for (int j = 0; j < span && made < RANDOM_WORDS; j++) begin
        r = $urandom_range(0, 99);
        if (r >= 95) cmd = CMD_SPARE;
        else if (mode == 0) cmd = (r < 65) ? CMD_ADD : (r < 80) ? CMD_DELETE : CMD_FIND;
        else if (mode == 1) cmd = (r < 15) ? CMD_ADD : (r < 75) ? CMD_DELETE : CMD_FIND;
        else cmd = (r < 35) ? CMD_ADD : (r < 65) ? CMD_DELETE : CMD_FIND;
        val = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 7)] : $urandom;
        queue_word(cmd, val);
        made++;
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (queued_words.size() != 0 || start || awaited_results.size() != 0)
      @(negedge clk);
    repeat (6) @(posedge clk);

    $display("covered %0d words: %0d adds (%0d refused on a full list), %0d deletes (%0d missed)",
             result_index, n_add, n_refused, n_delete, n_missed);
    $display("%0d finds (%0d hits, %0d with the spare code), deepest list %0d entries",
             n_find, n_hit, n_spare, deepest);
    if (errors == 0) begin
      $display("[ordered_list_insert_delete_search] OK");
    end else begin
      $display("[ordered_list_insert_delete_search] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/olis_pkg.sv
hw/rtl/olis_cell.sv
hw/rtl/ordered_list_insert_delete_search.sv
hw/rtl/olis_checker.sv
tb/ordered_list_insert_delete_search_test.sv
